[hw/rtl/pcrd_pkg.sv]
package pcrd_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int SKIP_W   = 10;
    localparam int NUM_W    = 16;
    localparam int COUNT_W  = 12;
    localparam int RATE_W   = 16;

    // Record length limit default
    localparam int MAX_RECORD_DEF = 4096;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUMERATOR = 2'd2;

    // Register reset values
    localparam logic signed [SAMPLE_W-1:0] THRESHOLD_RST = 16'sd12288;
    localparam logic [SKIP_W-1:0]          SKIP_RST      = 10'd180;
    localparam logic [NUM_W-1:0]           NUMERATOR_RST = 16'd60000;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 12'd4095;

    // Divider sequencing: one quotient bit per step
    localparam int DIV_STEPS = RATE_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Output word packing
    localparam int M_DATA_W = ((COUNT_W + RATE_W + 7) / 8) * 8;

    // Controller commands to the datapath
    typedef struct packed {
        logic accept;
        logic div_start;
        logic out_load;
        logic clear;
    } cmd_t;

    // Datapath status to the controller
    typedef struct packed {
        logic div_done;
        logic out_busy;
    } status_t;

endpackage

[hw/rtl/pcrd_div.sv]
module pcrd_div
    import pcrd_pkg::*;
#(
    parameter int DIVISOR_W = 13
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [NUM_W-1:0]     dividend,
    input  logic [DIVISOR_W-1:0] divisor,
    output logic                 done,
    output logic [RATE_W-1:0]    quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0]     quo_reg, quo_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] dsr_reg, dsr_next;

    logic [DIVISOR_W:0]   rem_shift;
    logic [DIVISOR_W:0]   rem_diff;
    logic                 fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign rem_shift = {rem_reg, quo_reg[NUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dsr_reg};
    assign fits      = rem_shift >= {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_STEPS);
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[NUM_W-2:0], fits};
            rem_next = fits ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = RATE_W'(quo_reg);

`ifndef NO_ASSERTIONS
    localparam int DONE_LAT = DIV_STEPS + 1;

    a_done_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        start && !busy_reg |-> ##DONE_LAT done_reg)
        else $error("divider done not seen at expected step count");

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !start)
        else $error("divider restarted while busy");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && dsr_reg != '0 |-> rem_reg < dsr_reg)
        else $error("partial remainder reached divisor");
`endif

endmodule

[hw/rtl/pcrd_datapath.sv]
module pcrd_datapath
    import pcrd_pkg::*;
#(
    parameter int MAX_RECORD = MAX_RECORD_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cmd_t                  cmd,
    output status_t               status,
    input  logic [SAMPLE_W-1:0]   sample,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [COUNT_W-1:0]    peak_count,
    output logic [RATE_W-1:0]     rate
);

    localparam int IDX_W = $clog2(MAX_RECORD + 1);
    localparam int SUM_W = ((IDX_W > SKIP_W) ? IDX_W : SKIP_W) + 1;

    // Configuration registers
    logic signed [SAMPLE_W-1:0] thr_reg;
    logic [SKIP_W-1:0]          skip_reg;
    logic [NUM_W-1:0]           num_reg;

    // Record state
    logic signed [SAMPLE_W-1:0] win_reg [4];
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic [IDX_W-1:0]           cand_reg, cand_next;
    logic [COUNT_W-1:0]         peaks_reg, peaks_next;
    logic [IDX_W-1:0]           first_reg, first_next;
    logic [IDX_W-1:0]           second_reg, second_next;

    // Output register
    logic                       mvalid_reg, mvalid_next;
    logic [COUNT_W-1:0]         cnt_out_reg;
    logic [RATE_W-1:0]          rate_out_reg;

    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] mid;
    logic                       in_range;
    logic [IDX_W-1:0]           centre;
    logic                       is_peak;
    logic [SKIP_W-1:0]          step;
    logic [SUM_W-1:0]           cand_sum;
    logic [IDX_W-1:0]           cand_sat;
    logic                       two_peaks;
    logic                       div_done;
    logic [RATE_W-1:0]          quotient;

    assign x   = sample;
    assign mid = win_reg[1];

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg  <= THRESHOLD_RST;
            skip_reg <= SKIP_RST;
            num_reg  <= NUMERATOR_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_THRESHOLD: thr_reg  <= cfg_wdata;
                CFG_SKIP:      skip_reg <= cfg_wdata[SKIP_W-1:0];
                CFG_NUMERATOR: num_reg  <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    // Peak test on the centre two samples back
    assign in_range = idx_reg < IDX_W'(MAX_RECORD);
    assign centre   = idx_reg - IDX_W'(2);
    assign is_peak  = cmd.accept && in_range && (idx_reg >= IDX_W'(4))
                      && (centre >= cand_reg) && (mid > thr_reg)
                      && (mid >= win_reg[3]) && (mid >= win_reg[2])
                      && (mid >= win_reg[0]) && (mid >= x);

    // Next centre after a peak, held at the record limit
    assign step     = (skip_reg == '0) ? SKIP_W'(1) : skip_reg;
    assign cand_sum = SUM_W'(centre) + SUM_W'(step);
    assign cand_sat = (cand_sum > SUM_W'(MAX_RECORD)) ? IDX_W'(MAX_RECORD)
                                                      : cand_sum[IDX_W-1:0];

    always_comb begin
        idx_next    = idx_reg;
        cand_next   = cand_reg;
        peaks_next  = peaks_reg;
        first_next  = first_reg;
        second_next = second_reg;
        if (cmd.clear) begin
            idx_next    = '0;
            cand_next   = IDX_W'(2);
            peaks_next  = '0;
            first_next  = '0;
            second_next = '0;
        end else begin
            if (cmd.accept && in_range) begin
                idx_next = idx_reg + IDX_W'(1);
            end
            if (is_peak) begin
                cand_next = cand_sat;
                if (peaks_reg == '0) begin
                    first_next = centre;
                end else if (peaks_reg == COUNT_W'(1)) begin
                    second_next = centre;
                end
                if (peaks_reg != COUNT_MAX) begin
                    peaks_next = peaks_reg + COUNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg    <= '0;
            cand_reg   <= IDX_W'(2);
            peaks_reg  <= '0;
            first_reg  <= '0;
            second_reg <= '0;
        end else begin
            idx_reg    <= idx_next;
            cand_reg   <= cand_next;
            peaks_reg  <= peaks_next;
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

    // Shift the sample window, newest first
    always_ff @(posedge aclk) begin
        if (cmd.accept && in_range) begin
            win_reg[3] <= win_reg[2];
            win_reg[2] <= win_reg[1];
            win_reg[1] <= win_reg[0];
            win_reg[0] <= x;
        end
    end

    // Rate divider on the first interval
    pcrd_div #(
        .DIVISOR_W (IDX_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (num_reg),
        .divisor  (second_reg - first_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign two_peaks = peaks_reg >= COUNT_W'(2);

    // Result word register
    always_comb begin
        mvalid_next = mvalid_reg;
        if (cmd.out_load) begin
            mvalid_next = 1'b1;
        end else if (m_tready) begin
            mvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= 1'b0;
        end else begin
            mvalid_reg <= mvalid_next;
        end
        if (cmd.out_load) begin
            cnt_out_reg  <= peaks_reg;
            rate_out_reg <= two_peaks ? quotient : '0;
        end
    end

    assign status.div_done = div_done;
    assign status.out_busy = mvalid_reg && !m_tready;
    assign m_tvalid        = mvalid_reg;
    assign peak_count      = cnt_out_reg;
    assign rate            = rate_out_reg;

`ifndef NO_ASSERTIONS
    a_cand_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cand_reg <= IDX_W'(MAX_RECORD))
        else $error("next centre beyond record limit");

    a_peak_order: assert property (@(posedge aclk) disable iff (!aresetn)
        two_peaks |-> first_reg < second_reg)
        else $error("second peak not after first peak");

    a_count_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.clear |=> peaks_reg >= $past(peaks_reg))
        else $error("peak count dropped inside a record");
`endif

endmodule

[hw/rtl/pcrd_ctrl.sv]
module pcrd_ctrl
    import pcrd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    input  logic    s_tlast,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_SCAN,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;

    // Decode commands and next state
    always_comb begin
        state_next    = state_reg;
        cmd.accept    = 1'b0;
        cmd.div_start = 1'b0;
        cmd.out_load  = 1'b0;
        cmd.clear     = 1'b0;
        s_tready      = 1'b0;
        unique case (state_reg)
            ST_SCAN: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid && s_tlast) begin
                    state_next = ST_DIV_LOAD;
                end
            end
            ST_DIV_LOAD: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_RUN;
            end
            ST_DIV_RUN: begin
                if (status.div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!status.out_busy) begin
                    cmd.out_load = 1'b1;
                    cmd.clear    = 1'b1;
                    state_next   = ST_SCAN;
                end
            end
            default: state_next = ST_SCAN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SCAN;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !status.out_busy)
        else $error("result loaded over an untaken word");

    a_last_starts_div: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept && s_tlast |=> cmd.div_start)
        else $error("divider not started after last word");

    a_done_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        status.div_done |-> state_reg == ST_DIV_RUN)
        else $error("divider finished outside its wait state");
`endif

endmodule

[hw/rtl/peak_count_rate_detector.sv]
// Peak count and rate detector. Each input word carries one signed Q2.14
// sample of a record, tlast marking the final sample. A centre sample is a
// peak when it is strictly above peak_threshold and not below the two
// samples on each side; after a peak the next centre tested is skip_distance
// further on. With the last sample one result word follows: the saturating
// peak count and rate_numerator divided by the first peak interval (0 with
// fewer than two peaks). Samples stream at one word per cycle inside a
// record. After the last word the input stalls while the divider is
// started, a 16-step restoring divider forms the rate and the result word
// is loaded, longer if the previous result word has not yet been taken. The
// user must write configuration only while idle; it is not enforced.
module peak_count_rate_detector
    import pcrd_pkg::*;
#(
    parameter int MAX_RECORD = MAX_RECORD_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Sample channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SAMPLE_W-1:0]   s_tdata,   // [15:0] sample
    input  logic                  s_tlast,
    // Result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // [11:0] peak_count, [27:12] rate
    // Configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cmd_t               cmd;
    status_t            status;
    logic [COUNT_W-1:0] peak_count;
    logic [RATE_W-1:0]  rate;

    pcrd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pcrd_datapath #(
        .MAX_RECORD (MAX_RECORD)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .sample     (s_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .peak_count (peak_count),
        .rate       (rate)
    );

    // Pack the result word, zero fill above
    assign m_tdata = M_DATA_W'({rate, peak_count});

endmodule
